// ===== hdl/stoc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stoc_pkg
// Shared sizes, the item record that moves from the front to the back, and
// the state type of the back sequencer.
// ----------------------------------------------------------------------------
package stoc_pkg;

  localparam int MAX_NODES = 1024;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int VALUE_W   = 32;
  localparam int LINK_W    = 11;
  localparam int SEEN_W    = 11;
  localparam int QUEUE_DEPTH = 2;

  // node memory row: key, left link, right link
  localparam int NODE_W  = VALUE_W + 2 * LINK_W;
  // bound memory row: lower bound, upper bound
  localparam int BOUND_W = 2 * VALUE_W;

  localparam logic [VALUE_W-1:0] KEY_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] KEY_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [LINK_W-1:0]  left_index;
    logic [LINK_W-1:0]  right_index;
    logic [CNT_W-1:0]   idx;          // 0-based position in the tree
    logic               first;
    logic               last;
    logic               left_link;    // left child names a node in range
    logic               right_link;
    logic               early_fail;   // fails without looking at memory
    logic [SEEN_W-1:0]  count;        // node count including this one
  } stoc_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stoc_queue_stat_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_FETCH,
    BK_CHECK
  } stoc_back_state_t;

endpackage
`default_nettype wire

// ===== hdl/search_tree_order_checker_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// search_tree_order_checker_top
// Checks a binary search tree given node by node in index order and gives
// one verdict per tree.
// ----------------------------------------------------------------------------
// A node is taken at a clock edge with start high and busy low. Each node
// passes through the checking sequencer's steps in order (parent-link read,
// parent row read, check and write-back), and the sequencer takes a new node
// only once it is through with the last one; a two-entry queue in front of
// the sequencer lets up to two further nodes be taken while one is checked.
// On the node marked last the verdict appears on tree_valid and nodes_seen
// for exactly one cycle with done high, after that node's check step; the
// receiver cannot hold it off. After reset the parent-link memory is swept
// once, one entry a cycle, and busy stays high until the sweep is over.
// ----------------------------------------------------------------------------
module search_tree_order_checker_top
  import stoc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [VALUE_W-1:0] node_value,
  input  wire logic [LINK_W-1:0]         left_index,
  input  wire logic [LINK_W-1:0]         right_index,
  input  wire logic                      last_node,
  output logic                           done,
  output logic                           tree_valid,
  output logic [SEEN_W-1:0]              nodes_seen
);

  stoc_item_t       push_item;
  stoc_item_t       head;
  stoc_queue_stat_t q_stat;
  logic             push;
  logic             pop;
  logic             clearing;

  stoc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .node_value  (node_value),
    .left_index  (left_index),
    .right_index (right_index),
    .last_node   (last_node),
    .q_stat      (q_stat),
    .clearing    (clearing),
    .busy        (busy),
    .push        (push),
    .item        (push_item)
  );

  stoc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  stoc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .clearing   (clearing),
    .done       (done),
    .tree_valid (tree_valid),
    .nodes_seen (nodes_seen)
  );

endmodule
`default_nettype wire

// ===== hdl/stoc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stoc_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module stoc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/stoc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stoc_queue
// Two-entry register queue between the front and the back.
// ----------------------------------------------------------------------------
module stoc_queue
  import stoc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire stoc_item_t push_item,
  input  wire logic       pop,
  output stoc_item_t      head,
  output stoc_queue_stat_t stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  stoc_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == FILL_W'(QUEUE_DEPTH));

endmodule
`default_nettype wire

// ===== hdl/stoc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stoc_front
// Accepts nodes, numbers them within the tree and flags everything that can
// be decided without memory: position overflow, out-of-range child indices
// and a node that names itself as child.
// ----------------------------------------------------------------------------
module stoc_front
  import stoc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [VALUE_W-1:0] node_value,
  input  wire logic [LINK_W-1:0]        left_index,
  input  wire logic [LINK_W-1:0]        right_index,
  input  wire logic                     last_node,
  input  wire stoc_queue_stat_t         q_stat,
  input  wire logic                     clearing,
  output logic                          busy,
  output logic                          push,
  output stoc_item_t                    item
);

  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [CNT_W-1:0]  cnt_inc;
  logic [LINK_W-1:0] own_code;
  logic              over;
  logic              left_bad;
  logic              right_bad;
  logic              self_named;

  assign busy = q_stat.full || clearing;
  assign push = start && !busy;

  always_comb begin
    over       = (cnt >= CNT_W'(MAX_NODES));
    cnt_inc    = over ? cnt : cnt + 1'b1;
    own_code   = LINK_W'(cnt_inc);
    left_bad   = (int'(left_index) > MAX_NODES);
    right_bad  = (int'(right_index) > MAX_NODES);
    self_named = (left_index == own_code) || (right_index == own_code);

    item.value       = node_value;
    item.left_index  = left_index;
    item.right_index = right_index;
    item.idx         = cnt;
    item.first       = (cnt == '0);
    item.last        = last_node;
    item.left_link   = (left_index != '0) && !left_bad;
    item.right_link  = (right_index != '0) && !right_bad;
    // the first node may name itself: it has no parent to check against
    item.early_fail  = over || left_bad || right_bad || (self_named && (cnt != '0));
    item.count       = SEEN_W'(cnt_inc);

    cnt_next = cnt;
    if (push) begin
      cnt_next = last_node ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/stoc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stoc_back
// Runs the memory side of each node in three steps: read the parent link of
// this node, read the parent's key, links and bounds, then check and write
// this node's row. Keeps the failure latch and issues the verdict.
// A parent link counts only if it points to an earlier node whose links name
// this node; that stands in for a per-tree parent mark without a clear.
// ----------------------------------------------------------------------------
module stoc_back
  import stoc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire stoc_item_t       head,
  input  wire stoc_queue_stat_t q_stat,
  output logic                  pop,
  output logic                  clearing,
  output logic                  done,
  output logic                  tree_valid,
  output logic [SEEN_W-1:0]     nodes_seen
);

  stoc_back_state_t st;
  stoc_back_state_t st_next;

  stoc_item_t        cur;
  stoc_item_t        cur_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] clr_addr_next;
  logic [ADDR_W-1:0] parent;
  logic [ADDR_W-1:0] parent_next;
  logic              fail;
  logic              fail_next;
  logic              done_next;
  logic              tree_valid_next;
  logic [SEEN_W-1:0] nodes_seen_next;

  // memory ports
  logic               par_we;
  logic [ADDR_W-1:0]  par_waddr;
  logic [ADDR_W-1:0]  par_wdata;
  logic [ADDR_W-1:0]  par_raddr;
  logic [ADDR_W-1:0]  par_rdata;
  logic               node_we;
  logic [NODE_W-1:0]  node_wdata;
  logic [NODE_W-1:0]  node_rdata;
  logic               bound_we;
  logic [BOUND_W-1:0] bound_wdata;
  logic [BOUND_W-1:0] bound_rdata;

  // parent entries and check
  logic signed [VALUE_W-1:0] v;
  logic signed [VALUE_W-1:0] pv;
  logic signed [VALUE_W-1:0] plo;
  logic signed [VALUE_W-1:0] phi;
  logic [LINK_W-1:0]         pleft;
  logic [LINK_W-1:0]         pright;
  logic [LINK_W-1:0]         own_code;
  logic [VALUE_W-1:0]        lo_new;
  logic [VALUE_W-1:0]        hi_new;
  logic                      ok;
  logic                      active;

  stoc_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  stoc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (cur.idx[ADDR_W-1:0]),
    .wdata (node_wdata),
    .raddr (par_rdata),
    .rdata (node_rdata)
  );

  stoc_ram #(.WIDTH(BOUND_W), .DEPTH(MAX_NODES)) u_bound_ram (
    .clk   (clk),
    .we    (bound_we),
    .waddr (cur.idx[ADDR_W-1:0]),
    .wdata (bound_wdata),
    .raddr (par_rdata),
    .rdata (bound_rdata)
  );

  always_comb begin
    v        = $signed(cur.value);
    pv       = $signed(node_rdata[NODE_W-1 -: VALUE_W]);
    pleft    = node_rdata[2*LINK_W-1 -: LINK_W];
    pright   = node_rdata[LINK_W-1:0];
    plo      = $signed(bound_rdata[BOUND_W-1 -: VALUE_W]);
    phi      = $signed(bound_rdata[VALUE_W-1:0]);
    own_code = LINK_W'(cur.idx + 1'b1);
    active   = !fail && !cur.early_fail;

    ok     = 1'b1;
    lo_new = KEY_MIN;
    hi_new = KEY_MAX;
    if (!cur.first) begin
      if (!((CNT_W'(parent) < cur.idx) && ((pleft == own_code) || (pright == own_code)))) begin
        ok = 1'b0;
      end else if (pv == v) begin
        ok = 1'b0;
      end else if (pv > v) begin
        ok     = (pleft == own_code) && (v > plo);
        lo_new = plo;
        hi_new = pv;
      end else begin
        ok     = (pright == own_code) && (v < phi);
        lo_new = pv;
        hi_new = phi;
      end
    end

    st_next         = st;
    cur_next        = cur;
    clr_addr_next   = clr_addr;
    parent_next     = parent;
    fail_next       = fail;
    done_next       = 1'b0;
    tree_valid_next = tree_valid;
    nodes_seen_next = nodes_seen;
    pop             = 1'b0;
    clearing        = 1'b0;
    par_we          = 1'b0;
    par_waddr       = clr_addr;
    par_wdata       = '0;
    par_raddr       = head.idx[ADDR_W-1:0];
    node_we         = 1'b0;
    node_wdata      = {cur.value, cur.left_index, cur.right_index};
    bound_we        = 1'b0;
    bound_wdata     = {lo_new, hi_new};

    case (st)
      BK_CLEAR: begin
        // give every parent link a defined value once after reset
        clearing  = 1'b1;
        par_we    = 1'b1;
        if (clr_addr == ADDR_W'(MAX_NODES - 1)) begin
          st_next = BK_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop      = 1'b1;
          cur_next = head;
          st_next  = BK_FETCH;
        end
      end
      BK_FETCH: begin
        parent_next = par_rdata;
        if (active && cur.left_link) begin
          par_we    = 1'b1;
          par_waddr = ADDR_W'(cur.left_index - 1'b1);
          par_wdata = cur.idx[ADDR_W-1:0];
        end
        st_next = BK_CHECK;
      end
      BK_CHECK: begin
        if (active) begin
          node_we  = 1'b1;
          bound_we = 1'b1;
          if (cur.right_link) begin
            par_we    = 1'b1;
            par_waddr = ADDR_W'(cur.right_index - 1'b1);
            par_wdata = cur.idx[ADDR_W-1:0];
          end
          fail_next = !ok;
        end else begin
          fail_next = 1'b1;
        end
        if (cur.last) begin
          done_next       = 1'b1;
          tree_valid_next = !fail_next;
          nodes_seen_next = cur.count;
          fail_next       = 1'b0;
        end
        st_next = BK_IDLE;
      end
      default: begin
        st_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= BK_CLEAR;
      clr_addr <= '0;
      fail     <= 1'b0;
      done     <= 1'b0;
    end else begin
      st       <= st_next;
      clr_addr <= clr_addr_next;
      fail     <= fail_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    parent     <= parent_next;
    tree_valid <= tree_valid_next;
    nodes_seen <= nodes_seen_next;
  end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: search tree order checker bench
// Sends whole trees node by node through the start/busy handshake and checks
// every verdict against a predictor that tracks the parent links, keys and
// open bounds per tree. A short directed set covers the extremes and each rule
// break; random trees follow, mostly well-formed binary search trees laid out
// in parent-before-child order, some with a single break, some pure noise,
// and one tree long enough to run past the node limit.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stoc_pkg::*;

  localparam int KEY_LO     = KEY_MIN;
  localparam int KEY_HI     = KEY_MAX;
  localparam int BIG_TREE   = MAX_NODES + 2;
  localparam int ITEM_GOAL  = 2000;
  localparam int DRAIN_WAIT = 20;

  typedef struct {
    bit               valid;
    bit [SEEN_W-1:0]  seen;
  } verdict_t;

  typedef enum int {
    MUT_NONE,
    MUT_EQUAL_PARENT,
    MUT_RANDOM_KEY,
    MUT_SWAP_SIDES,
    MUT_DROP_LINK,
    MUT_HUGE_INDEX,
    MUT_SELF_CHILD,
    MUT_EARLIER_CHILD,
    MUT_ANCESTOR_KEY,
    MUT_NOISE
  } tree_mutation_t;

  // predictor of the verdicts plus the queue of verdicts still to come
  class verdict_board;
    int              key_mem    [MAX_NODES];
    int              lo_mem     [MAX_NODES];
    int              hi_mem     [MAX_NODES];
    int unsigned     left_mem   [MAX_NODES];
    int unsigned     right_mem  [MAX_NODES];
    int unsigned     parent_mem [MAX_NODES];
    bit              marked     [MAX_NODES];
    int unsigned     node_count;
    bit              failed;
    verdict_t        verdicts[$];
    int              errors;
    int              checked_nodes;
    int              valid_seen;
    int              invalid_seen;

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function bit link_child(int unsigned child, int unsigned idx);
      if (child == 0) return 1'b1;
      if (child > MAX_NODES) return 1'b0;
      parent_mem[child-1] = idx;
      marked[child-1]     = 1'b1;
      return 1'b1;
    endfunction

    function bit node_in_order(int v, int unsigned lc, int unsigned rc, int unsigned idx);
      int unsigned p;
      int          pv;
      if (idx >= MAX_NODES) return 1'b0;
      key_mem[idx]   = v;
      left_mem[idx]  = (lc <= MAX_NODES) ? lc : 0;
      right_mem[idx] = (rc <= MAX_NODES) ? rc : 0;
      if (!link_child(lc, idx)) return 1'b0;
      if (!link_child(rc, idx)) return 1'b0;
      if (idx == 0) begin
        lo_mem[0] = KEY_LO;
        hi_mem[0] = KEY_HI;
        return 1'b1;
      end
      if (!marked[idx]) return 1'b0;
      p  = parent_mem[idx];
      pv = key_mem[p];
      if (pv == v) return 1'b0;
      if (pv > v) begin
        if (left_mem[p] != idx + 1) return 1'b0;
        if (v <= lo_mem[p]) return 1'b0;
        lo_mem[idx] = lo_mem[p];
        hi_mem[idx] = pv;
      end else begin
        if (right_mem[p] != idx + 1) return 1'b0;
        if (v >= hi_mem[p]) return 1'b0;
        lo_mem[idx] = pv;
        hi_mem[idx] = hi_mem[p];
      end
      return 1'b1;
    endfunction

    function void note_node(int v, bit [LINK_W-1:0] lc, bit [LINK_W-1:0] rc, bit last);
      verdict_t vd;
      if (!failed) begin
        checked_nodes++;
        if (!node_in_order(v, lc, rc, node_count)) failed = 1'b1;
      end
      if (node_count < MAX_NODES) node_count++;
      if (last) begin
        vd.valid = !failed;
        vd.seen  = node_count[SEEN_W-1:0];
        verdicts.push_back(vd);
        for (int i = 0; i < MAX_NODES; i++) marked[i] = 1'b0;
        node_count = 0;
        failed     = 1'b0;
      end
    endfunction

    function void check_verdict(logic got_valid, logic [SEEN_W-1:0] got_seen);
      verdict_t vd;
      if (verdicts.size() == 0) begin
        report($sformatf("verdict with none pending: tree_valid=%b nodes_seen=%0d",
                         got_valid, got_seen));
        return;
      end
      vd = verdicts.pop_front();
      if (vd.valid) valid_seen++;
      else invalid_seen++;
      if (got_valid !== vd.valid)
        report($sformatf("tree_valid expected %b got %b", vd.valid, got_valid));
      if (got_seen !== vd.seen)
        report($sformatf("nodes_seen expected %0d got %0d", vd.seen, got_seen));
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic signed [VALUE_W-1:0] node_value;
  logic [LINK_W-1:0]         left_index;
  logic [LINK_W-1:0]         right_index;
  logic                      last_node;
  logic                      done;
  logic                      tree_valid;
  logic [SEEN_W-1:0]         nodes_seen;

  verdict_board sb;

  // tree under construction, 1-based
  int unsigned lch     [BIG_TREE+1];
  int unsigned rch     [BIG_TREE+1];
  int unsigned par     [BIG_TREE+1];
  int          key_of  [BIG_TREE+1];
  int unsigned walk    [BIG_TREE+1];

  int burst_left;
  bit start_high;
  int trees_sent;
  int nodes_sent;

  search_tree_order_checker_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .node_value  (node_value),
    .left_index  (left_index),
    .right_index (right_index),
    .last_node   (last_node),
    .done        (done),
    .tree_valid  (tree_valid),
    .nodes_seen  (nodes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst == 1'b0 && done === 1'b1) sb.check_verdict(tree_valid, nodes_seen);
  end

  // offer one item and hold it until taken; then maybe pause the sender
  task automatic send_node(int v, bit [LINK_W-1:0] lc, bit [LINK_W-1:0] rc, bit last);
    int gap;
    start       <= 1'b1;
    start_high   = 1'b1;
    node_value  <= v;
    left_index  <= lc;
    right_index <= rc;
    last_node   <= last;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_node(v, lc, rc, last);
    nodes_sent++;
    if (last) trees_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start     <= 1'b0;
        start_high = 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // random shape with every parent ahead of its children, keys by in-order walk
  task automatic build_tree(int n);
    int          tries;
    int unsigned p;
    int unsigned cur;
    int          sp;
    int          pos;
    longint      span;
    longint      step_max;
    longint      k;
    for (int i = 1; i <= n; i++) begin
      lch[i] = 0;
      rch[i] = 0;
      par[i] = 0;
    end
    for (int i = 2; i <= n; i++) begin
      tries = 0;
      do begin
        if ($urandom_range(0, 2) == 0) p = $urandom_range((i > 4) ? i - 4 : 1, i - 1);
        else p = $urandom_range(1, i - 1);
        tries++;
        if (tries > 8) p = i - 1;
      end while (lch[p] != 0 && rch[p] != 0);
      if (lch[p] == 0 && (rch[p] != 0 || $urandom_range(0, 1) == 0)) lch[p] = i;
      else rch[p] = i;
      par[i] = p;
    end
    sp  = 0;
    pos = 0;
    cur = 1;
    while (cur != 0 || sp > 0) begin
      while (cur != 0) begin
        walk[sp] = cur;
        sp++;
        cur = lch[cur];
      end
      sp--;
      cur = walk[sp];
      pos++;
      lch[0] = cur;
      key_of[cur] = pos;
      cur = rch[cur];
    end
    lch[0] = 0;
    // key_of holds the in-order rank for now; map ranks to rising keys
    span     = 64'd4294967293;
    step_max = ($urandom_range(0, 2) == 0) ? longint'($urandom_range(1, 4)) : span / n;
    k        = longint'(KEY_LO) + longint'($urandom_range(0, 32'(span - n * step_max)));
    for (int r = 1; r <= n; r++) begin
      k += longint'($urandom_range(1, 32'(step_max)));
      for (int i = 1; i <= n; i++) if (key_of[i] == r && walk[0] != 0) key_of[i] = key_of[i];
      walk[r] = 32'(k);
    end
    for (int i = 1; i <= n; i++) key_of[i] = walk[key_of[i]];
  endtask

  task automatic break_tree(int n, tree_mutation_t how);
    int unsigned m;
    int unsigned tmp;
    m = $urandom_range(1, n);
    case (how)
      MUT_EQUAL_PARENT: if (m > 1) key_of[m] = key_of[par[m]];
      MUT_RANDOM_KEY:   key_of[m] = $urandom;
      MUT_SWAP_SIDES: begin
        tmp    = lch[m];
        lch[m] = rch[m];
        rch[m] = tmp;
      end
      MUT_DROP_LINK: begin
        if (lch[m] != 0) lch[m] = 0;
        else rch[m] = 0;
      end
      MUT_HUGE_INDEX: begin
        if ($urandom_range(0, 1) == 0) lch[m] = $urandom_range(MAX_NODES + 1, 2047);
        else rch[m] = $urandom_range(MAX_NODES + 1, 2047);
      end
      MUT_SELF_CHILD: begin
        if ($urandom_range(0, 1) == 0) lch[m] = m;
        else rch[m] = m;
      end
      MUT_EARLIER_CHILD: begin
        if ($urandom_range(0, 1) == 0) lch[m] = $urandom_range(1, m);
        else rch[m] = $urandom_range(1, m);
      end
      MUT_ANCESTOR_KEY: if (m > 1 && par[m] > 1) key_of[m] = key_of[par[par[m]]];
      MUT_NOISE: begin
        for (int i = 1; i <= n; i++) begin
          key_of[i] = $urandom;
          lch[i]    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                  : $urandom_range(0, n + 1);
          rch[i]    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                  : $urandom_range(0, n + 1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_tree(int n);
    for (int i = 1; i <= n; i++) send_node(key_of[i], lch[i][LINK_W-1:0],
                                           rch[i][LINK_W-1:0], i == n);
  endtask

  initial begin
    int             n;
    int             sel;
    int             waited;
    tree_mutation_t how;
    sb          = new();
    rst         <= 1'b1;
    start       <= 1'b0;
    node_value  <= '0;
    left_index  <= '0;
    right_index <= '0;
    last_node   <= 1'b0;
    start_high   = 1'b0;
    burst_left   = $urandom_range(1, 30);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // single nodes at both key extremes, one naming child 1024
    send_node(KEY_LO, 0, 0, 1);
    send_node(KEY_HI, LINK_W'(MAX_NODES), 0, 1);
    // children right inside the full range
    send_node(0, 2, 3, 0);
    send_node(KEY_LO + 1, 0, 0, 0);
    send_node(KEY_HI - 1, 0, 0, 1);
    // right child on the open upper bound
    send_node(0, 0, 2, 0);
    send_node(KEY_HI, 0, 0, 1);
    // equal key, then items that are only counted
    send_node(5, 2, 0, 0);
    send_node(5, 0, 0, 0);
    send_node(-7, 1023, 2047, 0);
    send_node(99, 0, 0, 1);
    // larger key hung on the left
    send_node(5, 2, 0, 0);
    send_node(9, 0, 0, 1);
    // node with no parent linked
    send_node(5, 2, 0, 0);
    send_node(3, 0, 0, 0);
    send_node(1, 0, 0, 1);
    // child index past the node limit
    send_node(-1, 0, 2047, 1);
    // node naming itself
    send_node(0, 0, 2, 0);
    send_node(10, 0, 2, 1);
    // node naming an earlier node
    send_node(10, 2, 0, 0);
    send_node(5, 1, 0, 1);
    // bound narrowed by the grandparent
    send_node(0, 2, 0, 0);
    send_node(-10, 0, 3, 0);
    send_node(5, 0, 0, 1);

    while (nodes_sent < ITEM_GOAL) begin
      if (trees_sent == 60) begin
        // fills every slot, then runs past the limit
        build_tree(BIG_TREE);
        send_tree(BIG_TREE);
      end
      sel = $urandom_range(0, 9);
      if (sel < 3) n = $urandom_range(1, 3);
      else if (sel < 9) n = $urandom_range(1, 12);
      else n = $urandom_range(13, 60);
      build_tree(n);
      sel = $urandom_range(0, 17);
      how = (sel < 9) ? MUT_NONE : tree_mutation_t'(sel - 8);
      break_tree(n, how);
      send_tree(n);
    end
    if (start_high) start <= 1'b0;

    waited = 0;
    while (sb.verdicts.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.verdicts.size() != 0)
      sb.report($sformatf("%0d verdicts never arrived", sb.verdicts.size()));

    $display("Covered %0d trees, %0d nodes (%0d checked); verdicts %0d valid, %0d invalid",
             trees_sent, nodes_sent, sb.checked_nodes, sb.valid_seen, sb.invalid_seen);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/stoc_pkg.sv
hdl/stoc_ram.sv
hdl/stoc_queue.sv
hdl/stoc_front.sv
hdl/stoc_back.sv
hdl/search_tree_order_checker_top.sv
bench/tb_top.sv
